/* hdl/motor_reply_frame_parser_defines.svh */
// Assertion macros shared by the motor reply frame parser RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef MOTOR_REPLY_FRAME_PARSER_DEFINES_SVH
`define MOTOR_REPLY_FRAME_PARSER_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define MRFP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("motor reply frame parser: same-cycle check failed");

// Antecedent implies consequent in the next cycle.
`define MRFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("motor reply frame parser: next-cycle check failed");

`endif

/* hdl/mrfp_pkg.sv */
// Types, frame constants and helper functions for the motor reply frame parser.
// Depends on nothing; imported by the parser top level.
package mrfp_pkg;

  localparam logic [7:0] HDR_BYTE  = 8'hA5;
  localparam logic [7:0] CMD_SPEED = 8'h02;
  localparam logic [7:0] CMD_ANGLE = 8'h04;
  localparam logic [7:0] CMD_LOC   = 8'h05;

  localparam int unsigned FRAME_LEN = 7;
  localparam logic [2:0] POS_HUNT  = 3'd0;
  localparam logic [2:0] POS_CMD   = 3'd1;
  localparam logic [2:0] POS_FIRST = 3'd2;
  localparam logic [2:0] POS_CSUM  = 3'(FRAME_LEN - 1);

  localparam logic REG_LEFT_NEGATE  = 1'b0;
  localparam logic REG_RIGHT_NEGATE = 1'b1;

  typedef enum logic [2:0] {
    KIND_SPEED = 3'd0,
    KIND_ANGLE = 3'd1,
    KIND_LOC   = 3'd2,
    KIND_OTHER = 3'd3,
    KIND_ERROR = 3'd4
  } frame_kind_t;

  typedef logic signed [15:0] value_t;

  function automatic value_t negate_sat(input value_t v, input logic neg);
    value_t res;
    if (!neg) begin
      res = v;
    end else if (v == 16'sh8000) begin
      res = 16'sh7FFF;
    end else begin
      res = -v;
    end
    return res;
  endfunction

endpackage

/* hdl/motor_reply_frame_parser.sv */
// Motor reply frame parser: hunts for header 0xA5 and decodes 7-byte reply frames.
// A checksum word is held in the input register, then its result is written to the result register.
// Throughput: one word per cycle; only a stalled result holding the output register
// can stall the input, and then only for the checksum word of a frame.
// Reset (rst_n, synchronous, active low) empties both stages, clears the negate
// registers and returns the parser to header hunting. Depends on mrfp_pkg and the defines header.
`include "motor_reply_frame_parser_defines.svh"

module motor_reply_frame_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [7:0]           in_rx_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output mrfp_pkg::frame_kind_t out_frame_kind,
  output mrfp_pkg::value_t     out_left_value,
  output mrfp_pkg::value_t     out_right_value,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [2:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mrfp_pkg::*;

  logic        left_neg_r;
  logic        right_neg_r;

  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;

  logic [2:0]  pos_r;
  logic [2:0]  pos_nxt;
  logic [7:0]  sum_r;
  logic [7:0]  sum_nxt;
  logic [7:0]  cmd_r;
  logic [7:0]  payload_r [4];
  logic [1:0]  pay_idx;

  logic        s1_res;
  logic        s1_adv;
  logic        in_fire;

  frame_kind_t kind_nxt;
  value_t      left_nxt;
  value_t      right_nxt;
  value_t      left_raw;
  value_t      right_raw;

  logic        out_valid_r;
  frame_kind_t kind_r;
  value_t      left_r;
  value_t      right_r;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = {31'b0, (paddr[2] == REG_RIGHT_NEGATE) ? right_neg_r : left_neg_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_neg_r  <= 1'b0;
      right_neg_r <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_LEFT_NEGATE:  left_neg_r  <= pwdata[0];
        REG_RIGHT_NEGATE: right_neg_r <= pwdata[0];
        default:          left_neg_r  <= left_neg_r;
      endcase
    end
  end

  // Handshake between the input register and the result register
  assign s1_res   = (pos_r == POS_CSUM);
  assign s1_adv   = s1_valid_r && (!s1_res || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_fire  = in_valid && !in_stall;

  assign pay_idx   = 2'(pos_r - POS_FIRST);
  assign left_raw  = {payload_r[0], payload_r[1]};
  assign right_raw = {payload_r[2], payload_r[3]};

  always_comb begin
    pos_nxt = pos_r;
    sum_nxt = sum_r;
    if (pos_r == POS_HUNT || pos_r > POS_CSUM) begin
      if (s1_byte_r == HDR_BYTE) begin
        pos_nxt = POS_CMD;
        sum_nxt = s1_byte_r;
      end else begin
        pos_nxt = POS_HUNT;
      end
    end else if (pos_r == POS_CSUM) begin
      pos_nxt = POS_HUNT;
      sum_nxt = 8'd0;
    end else begin
      pos_nxt = pos_r + 3'd1;
      sum_nxt = sum_r + s1_byte_r;
    end
  end

  always_comb begin
    kind_nxt  = KIND_OTHER;
    left_nxt  = '0;
    right_nxt = '0;
    if (s1_byte_r != sum_r) begin
      kind_nxt = KIND_ERROR;
    end else begin
      unique case (cmd_r)
        CMD_SPEED: begin
          kind_nxt  = KIND_SPEED;
          left_nxt  = left_raw;
          right_nxt = right_raw;
        end
        CMD_ANGLE: begin
          kind_nxt  = KIND_ANGLE;
          left_nxt  = left_raw;
          right_nxt = right_raw;
        end
        CMD_LOC: begin
          kind_nxt  = KIND_LOC;
          left_nxt  = negate_sat(left_raw, left_neg_r);
          right_nxt = negate_sat(right_raw, right_neg_r);
        end
        default: begin
          kind_nxt = KIND_OTHER;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pos_r      <= POS_HUNT;
      sum_r      <= 8'd0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        pos_r <= pos_nxt;
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_rx_byte;
    end
    if (s1_adv && pos_r == POS_CMD) begin
      cmd_r <= s1_byte_r;
    end
    if (s1_adv && pos_r >= POS_FIRST && pos_r < POS_CSUM) begin
      payload_r[pay_idx] <= s1_byte_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_res) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_res) begin
      kind_r  <= kind_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_frame_kind  = kind_r;
  assign out_left_value  = left_r;
  assign out_right_value = right_r;

  `MRFP_ASSERT_IMPL(a_pos_range, clk, rst_n, 1'b1, pos_r <= POS_CSUM)
  `MRFP_ASSERT_NEXT(a_csum_gives_result, clk, rst_n, s1_adv && pos_r == POS_CSUM, out_valid_r)
  `MRFP_ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall,
                    s1_valid_r && out_valid_r && out_stall && pos_r == POS_CSUM)
  `MRFP_ASSERT_IMPL(a_error_zero, clk, rst_n, out_valid_r && kind_r == KIND_ERROR,
                    left_r == 16'sd0 && right_r == 16'sd0)

endmodule

/* test/motor_reply_frame_parser_test.sv */
// Self-checking test of the motor reply frame parser: directed frames, then random
// byte streams under several idling patterns, each result compared with a local decoder.
// Depends on mrfp_pkg and the motor_reply_frame_parser RTL.
module motor_reply_frame_parser_test;
  import mrfp_pkg::*;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam logic [2:0] ADDR_LEFT_NEGATE  = {REG_LEFT_NEGATE, 2'b00};
  localparam logic [2:0] ADDR_RIGHT_NEGATE = {REG_RIGHT_NEGATE, 2'b00};

  typedef struct packed {
    frame_kind_t kind;
    value_t      left;
    value_t      right;
  } reply_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  frame_kind_t out_frame_kind;
  value_t      out_left_value;
  value_t      out_right_value;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  reply_t      pending_replies[$];
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned frame_words_sent;

  // Decoder state kept alongside the block.
  logic [2:0]  frame_pos = POS_HUNT;
  logic [7:0]  frame_sum = 8'd0;
  logic [7:0]  frame_cmd = 8'd0;
  logic [7:0]  frame_payload[4];
  logic        negate_left = 1'b0;
  logic        negate_right = 1'b0;

  motor_reply_frame_parser uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_stall(out_stall), .out_frame_kind(out_frame_kind),
    .out_left_value(out_left_value), .out_right_value(out_right_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic value_t apply_direction(input value_t v, input logic negate);
    if (!negate) return v;
    if (v == value_t'(-32768)) return value_t'(32767);
    return -v;
  endfunction

  task automatic decode_word(input logic [7:0] b);
    reply_t r;
    value_t l_raw;
    value_t r_raw;
    if (frame_pos == POS_HUNT || frame_pos >= 3'(FRAME_LEN)) begin
      if (b == HDR_BYTE) begin
        frame_sum = b;
        frame_pos = POS_CMD;
      end else begin
        frame_pos = POS_HUNT;
      end
    end else if (frame_pos == POS_CMD) begin
      frame_cmd = b;
      frame_sum = frame_sum + b;
      frame_pos = POS_FIRST;
    end else if (frame_pos < POS_CSUM) begin
      frame_payload[2'(frame_pos - POS_FIRST)] = b;
      frame_sum = frame_sum + b;
      frame_pos = frame_pos + 3'd1;
    end else begin
      l_raw = {frame_payload[0], frame_payload[1]};
      r_raw = {frame_payload[2], frame_payload[3]};
      r = '{kind: KIND_OTHER, left: '0, right: '0};
      if (b != frame_sum) begin
        r.kind = KIND_ERROR;
      end else if (frame_cmd == CMD_SPEED) begin
        r = '{kind: KIND_SPEED, left: l_raw, right: r_raw};
      end else if (frame_cmd == CMD_ANGLE) begin
        r = '{kind: KIND_ANGLE, left: l_raw, right: r_raw};
      end else if (frame_cmd == CMD_LOC) begin
        r = '{kind: KIND_LOC, left: apply_direction(l_raw, negate_left),
              right: apply_direction(r_raw, negate_right)};
      end
      pending_replies.push_back(r);
      frame_pos = POS_HUNT;
      frame_sum = 8'd0;
    end
  endtask

  task automatic send_word(input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    decode_word(b);
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] l, input logic [15:0] r,
                            input logic corrupt);
    logic [7:0] csum;
    csum = HDR_BYTE + cmd + l[15:8] + l[7:0] + r[15:8] + r[7:0];
    if (corrupt) csum = csum ^ 8'($urandom_range(1, 255));
    send_word(HDR_BYTE);
    send_word(cmd);
    send_word(l[15:8]);
    send_word(l[7:0]);
    send_word(r[15:8]);
    send_word(r[7:0]);
    send_word(csum);
    frame_words_sent += 7;
  endtask

  // Waits until every reply has arrived and the pipeline has emptied.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic bit_value);
    logic [31:0] data;
    data = $urandom();
    data[0] = bit_value;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == ADDR_LEFT_NEGATE) negate_left = bit_value;
    else negate_right = bit_value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_directions(input logic l, input logic r);
    settle();
    write_reg(ADDR_LEFT_NEGATE, l);
    write_reg(ADDR_RIGHT_NEGATE, r);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      4: return HDR_BYTE;
      default: return 8'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_command();
    case ($urandom_range(4))
      0: return CMD_SPEED;
      1: return CMD_ANGLE;
      2: return CMD_LOC;
      3: return 8'($urandom());
      default: return CMD_LOC;
    endcase
  endfunction

  task automatic test_frame_kinds();
    send_word(8'h00);
    send_frame(CMD_SPEED, 16'h8000, 16'h7FFF, 1'b0);
    send_frame(CMD_ANGLE, {HDR_BYTE, 8'hFF}, 16'h0000, 1'b0);
    // A header arriving as a bad checksum must not open a new frame.
    send_word(HDR_BYTE);
    send_word(CMD_ANGLE);
    repeat (4) send_word(8'h00);
    send_word(HDR_BYTE);
    send_word(CMD_SPEED);
  endtask

  task automatic test_location_direction();
    for (int i = 0; i < 4; i++) begin
      set_directions(i[0], i[1]);
      send_frame(CMD_LOC, 16'h8000, 16'h0001, 1'b0);
    end
    send_frame(HDR_BYTE, 16'h1234, 16'hFEDC, 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned n_words, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    set_directions(1'($urandom_range(1)), 1'($urandom_range(1)));
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    frame_words_sent = 0;
    while (frame_words_sent < n_words) begin
      case ($urandom_range(19))
        0, 1: repeat ($urandom_range(1, 3)) send_word(pick_byte());
        2: begin
          // Truncated frame: its bytes run into the next one.
          send_word(HDR_BYTE);
          repeat ($urandom_range(1, 5)) send_word(pick_byte());
        end
        default: send_frame(pick_command(), {pick_byte(), pick_byte()},
                            {pick_byte(), pick_byte()}, $urandom_range(6) == 0);
      endcase
    end
    settle();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= $urandom_range(99) < receiver_stall_pct;
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply, kind %0d left %0d right %0d", $time,
                 out_frame_kind, out_left_value, out_right_value);
        mismatches++;
      end else begin
        want = pending_replies.pop_front();
        if (out_frame_kind !== want.kind) begin
          $display("%0t: frame_kind expected %0d actual %0d", $time, want.kind, out_frame_kind);
          mismatches++;
        end
        if (out_left_value !== want.left) begin
          $display("%0t: left_value expected %0d actual %0d", $time, want.left, out_left_value);
          mismatches++;
        end
        if (out_right_value !== want.right) begin
          $display("%0t: right_value expected %0d actual %0d", $time, want.right,
                   out_right_value);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_frame_kinds();
    test_location_direction();
    test_random_traffic(375, 0, 0);
    test_random_traffic(375, 82, 0);
    test_random_traffic(375, 0, 82);
    test_random_traffic(375, 25, 25);
    settle();
    repeat (5) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/mrfp_pkg.sv
hdl/motor_reply_frame_parser.sv
test/motor_reply_frame_parser_test.sv
